FILE: src/psma_pkg.sv
package psma_pkg;

    // Default width of the running movement sums.
    localparam int SUM_WIDTH_DEFAULT = 16;

    // Width of the reported movement fields.
    localparam int OUT_WIDTH = 16;

    // Item command codes.
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    // Header byte fields.
    localparam logic [7:0] SYNC_BIT      = 8'h08;
    localparam logic [7:0] OVERFLOW_MASK = 8'hc0;
    localparam int         BUTTON_BITS   = 3;

    // Framing positions within a packet.
    localparam logic [1:0] POS_HEAD = 2'd0;
    localparam logic [1:0] POS_X    = 2'd1;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
        logic       from_aux;
    } in_item_t;

    typedef struct packed {
        logic                          event_valid;
        logic signed [OUT_WIDTH-1:0]   delta_x;
        logic signed [OUT_WIDTH-1:0]   delta_y;
        logic [BUTTON_BITS-1:0]        button_bits;
    } out_item_t;

endpackage

FILE: src/ps2_mouse_packet_accumulator.sv
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    psma_pkg::in_item_t (command, data_byte, from_aux)
// out       output     out_valid / out_ready  psma_pkg::out_item_t (event_valid, deltas, buttons)
// cfg       input      cfg_write              cfg_data (enable)
//
// An accepted item is held in an input register and processed there, and a scan that finds
// a pending event loads the output register. One item is accepted per cycle while the input
// register is not stalled; the single output register is the only point of stall.
// Only a scan that would produce a result waits for the output register to empty; byte items
// and empty scans pass through regardless. Reset clears framing, sums, buttons and the enable.
module ps2_mouse_packet_accumulator #(
    parameter int SUM_WIDTH = psma_pkg::SUM_WIDTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  psma_pkg::in_item_t   in_data,

    output logic                 out_valid,
    input  logic                 out_ready,
    output psma_pkg::out_item_t  out_data,

    input  logic                 cfg_write,
    input  logic                 cfg_data
);

    localparam int OW    = psma_pkg::OUT_WIDTH;
    localparam int EXT_W = (SUM_WIDTH > OW) ? SUM_WIDTH : OW;

    // Saturation bounds of the running sums, one bit wider than the sums so that the
    // unclamped sum of a sum and one movement byte always fits.
    localparam logic signed [SUM_WIDTH:0] SUM_MAX =
        $signed({2'b00, {(SUM_WIDTH-1){1'b1}}});
    localparam logic signed [SUM_WIDTH:0] SUM_MIN =
        $signed({2'b11, {(SUM_WIDTH-1){1'b0}}});

    // Bounds of the reported fields, at a width that holds any sum.
    localparam logic signed [EXT_W-1:0] OUT_MAX = EXT_W'(32767);
    localparam logic signed [EXT_W-1:0] OUT_MIN = EXT_W'(-32768);

    // Input stage.
    logic                 item_valid_reg;
    psma_pkg::in_item_t   item_reg;

    // Configuration.
    logic                 enable_reg;

    // Packet framing and accumulation state.
    logic [7:0]                    head_byte_reg,       head_byte_next;
    logic [7:0]                    x_byte_reg,          x_byte_next;
    logic [1:0]                    byte_position_reg,   byte_position_next;
    logic signed [SUM_WIDTH-1:0]   sum_x_reg,           sum_x_next;
    logic signed [SUM_WIDTH-1:0]   sum_y_reg,           sum_y_next;
    logic [psma_pkg::BUTTON_BITS-1:0] latched_buttons_reg, latched_buttons_next;
    logic                          pending_flag_reg,    pending_flag_next;

    // Output stage.
    logic                 out_valid_reg;
    psma_pkg::out_item_t  out_item_reg;

    logic                 is_scan;
    logic                 emit;
    logic                 advance;

    logic signed [SUM_WIDTH:0]  add_x;
    logic signed [SUM_WIDTH:0]  add_y;
    logic signed [SUM_WIDTH-1:0] sat_x;
    logic signed [SUM_WIDTH-1:0] sat_y;
    logic signed [EXT_W-1:0]    ext_x;
    logic signed [EXT_W-1:0]    ext_y;
    logic signed [OW-1:0]       rep_x;
    logic signed [OW-1:0]       rep_y;

    // A scan with a pending event needs the output register; everything else never stalls.
    assign is_scan  = (item_reg.command == psma_pkg::CMD_SCAN);
    assign emit     = item_valid_reg && is_scan && pending_flag_reg;
    assign advance  = item_valid_reg && (!emit || !out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    // Saturating accumulation: X is sign-extended, Y is sign-extended and negated so that
    // screen-down is positive.
    always_comb
    begin
        add_x = (SUM_WIDTH+1)'(sum_x_reg) + (SUM_WIDTH+1)'($signed(x_byte_reg));
        add_y = (SUM_WIDTH+1)'(sum_y_reg) - (SUM_WIDTH+1)'($signed(item_reg.data_byte));

        if (add_x > SUM_MAX)
            sat_x = SUM_MAX[SUM_WIDTH-1:0];
        else if (add_x < SUM_MIN)
            sat_x = SUM_MIN[SUM_WIDTH-1:0];
        else
            sat_x = add_x[SUM_WIDTH-1:0];

        if (add_y > SUM_MAX)
            sat_y = SUM_MAX[SUM_WIDTH-1:0];
        else if (add_y < SUM_MIN)
            sat_y = SUM_MIN[SUM_WIDTH-1:0];
        else
            sat_y = add_y[SUM_WIDTH-1:0];
    end

    // Reported deltas clamp to the 16-bit field range when the sums are wider.
    always_comb
    begin
        ext_x = EXT_W'(sum_x_reg);
        ext_y = EXT_W'(sum_y_reg);

        if (ext_x > OUT_MAX)
            rep_x = OUT_MAX[OW-1:0];
        else if (ext_x < OUT_MIN)
            rep_x = OUT_MIN[OW-1:0];
        else
            rep_x = ext_x[OW-1:0];

        if (ext_y > OUT_MAX)
            rep_y = OUT_MAX[OW-1:0];
        else if (ext_y < OUT_MIN)
            rep_y = OUT_MIN[OW-1:0];
        else
            rep_y = ext_y[OW-1:0];
    end

    // Per-item state update.
    always_comb
    begin
        head_byte_next       = head_byte_reg;
        x_byte_next          = x_byte_reg;
        byte_position_next   = byte_position_reg;
        sum_x_next           = sum_x_reg;
        sum_y_next           = sum_y_reg;
        latched_buttons_next = latched_buttons_reg;
        pending_flag_next    = pending_flag_reg;

        if (advance)
        begin
            if (is_scan)
            begin
                // The sums clear only when a result is reported.
                if (pending_flag_reg)
                begin
                    sum_x_next        = '0;
                    sum_y_next        = '0;
                    pending_flag_next = 1'b0;
                end
            end
            else if (enable_reg && item_reg.from_aux)
            begin
                if (byte_position_reg == psma_pkg::POS_HEAD)
                begin
                    // A packet starts only on a byte carrying the sync bit.
                    if ((item_reg.data_byte & psma_pkg::SYNC_BIT) != 8'h00)
                    begin
                        head_byte_next     = item_reg.data_byte;
                        byte_position_next = psma_pkg::POS_X;
                    end
                end
                else if (byte_position_reg == psma_pkg::POS_X)
                begin
                    x_byte_next        = item_reg.data_byte;
                    byte_position_next = byte_position_reg + 2'd1;
                end
                else
                begin
                    // Third byte: the packet is complete. Overflow packets are dropped.
                    byte_position_next = psma_pkg::POS_HEAD;
                    if ((head_byte_reg & psma_pkg::OVERFLOW_MASK) == 8'h00)
                    begin
                        sum_x_next           = sat_x;
                        sum_y_next           = sat_y;
                        latched_buttons_next = head_byte_reg[psma_pkg::BUTTON_BITS-1:0];
                        pending_flag_next    = 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg      <= 1'b0;
            enable_reg          <= 1'b0;
            head_byte_reg       <= '0;
            x_byte_reg          <= '0;
            byte_position_reg   <= psma_pkg::POS_HEAD;
            sum_x_reg           <= '0;
            sum_y_reg           <= '0;
            latched_buttons_reg <= '0;
            pending_flag_reg    <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                enable_reg <= cfg_data;

            if (in_ready)
                item_valid_reg <= in_valid;

            head_byte_reg       <= head_byte_next;
            x_byte_reg          <= x_byte_next;
            byte_position_reg   <= byte_position_next;
            sum_x_reg           <= sum_x_next;
            sum_y_reg           <= sum_y_next;
            latched_buttons_reg <= latched_buttons_next;
            pending_flag_reg    <= pending_flag_next;

            if (advance && emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            item_reg <= in_data;

        if (advance && emit)
        begin
            out_item_reg.event_valid <= 1'b1;
            out_item_reg.delta_x     <= rep_x;
            out_item_reg.delta_y     <= rep_y;
            out_item_reg.button_bits <= latched_buttons_reg;
        end
    end

endmodule
